// ===== hw/rtl/sprq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprq_pkg
// Shared types, sizes and codes for the stable priority release queue.
// ----------------------------------------------------------------------------
package sprq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 31;
    localparam int ID_W    = 16;
    localparam int COUNT_W = 7;
    localparam int ACT_W   = 2;
    localparam int ENTRY_W = VALUE_W + ID_W;

    localparam int S_TDATA_W = 56;  // value, id, count, padded to bytes
    localparam int M_TDATA_W = 48;  // entry_id, entry_value, padded to bytes

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_DRAIN   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_INS_HEAD,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // a leaves before b: larger value, then smaller id
    function automatic logic goes_first(input entry_t a, input entry_t b);
        logic r;
        if (a.value != b.value) begin
            r = (a.value > b.value);
        end else begin
            r = (a.id < b.id);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/stable_priority_release_queue_unit.sv =====
`timescale 1ns / 1ps
// Push: an empty queue takes the entry straight into the store; otherwise the
//   insertion walks the sorted store downward one entry per cycle (one RAM read
//   and one RAM write each cycle).
// Release/drain: the first result passes through ST_RELEASE and the output register,
//   then one result per cycle from the top of the store while the output is taken.
// Reset clears the fill count and control state; store contents are undefined.
// ----------------------------------------------------------------------------
// stable_priority_release_queue_unit
// Bounded priority queue kept sorted in RAM, best entry at the highest index.
// ----------------------------------------------------------------------------
module stable_priority_release_queue_unit
    import sprq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] value, [46:31] id, [53:47] count
    input  logic [ACT_W-1:0]     s_tuser,   // [1:0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] entry_id, [46:16] entry_value
    output logic                 m_tlast
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    entry_t             new_reg, new_next;
    logic               out_valid_reg, out_valid_next;
    entry_t             out_entry_reg, out_entry_next;
    logic               out_last_reg, out_last_next;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    entry_t             rd_data;

    entry_t             in_entry;
    logic [COUNT_W-1:0] in_count;
    logic [COUNT_W-1:0] fill_ext;
    logic [COUNT_W-1:0] rel_n;
    logic [CNT_W-1:0]   fill_dec;
    logic [ADDR_W-1:0]  idx_dec;
    logic [ADDR_W-1:0]  idx_inc;
    logic               accept;
    logic               out_free;

    sprq_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_entry.value = s_tdata[VALUE_W-1:0];
    assign in_entry.id    = s_tdata[VALUE_W+ID_W-1:VALUE_W];
    assign in_count       = s_tdata[VALUE_W+ID_W+COUNT_W-1:VALUE_W+ID_W];
    assign fill_ext       = COUNT_W'(fill_reg);
    assign rel_n          = (in_count < fill_ext) ? in_count : fill_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_dec  = idx_reg - ADDR_W'(1);
    assign idx_inc  = idx_reg + ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        new_reg       <= new_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        new_next       = new_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_inc;
        wr_data        = new_reg;
        fill_dec       = '0;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (action_t'(s_tuser))
                        ACT_PUSH: begin
                            if (fill_reg == CNT_W'(DEPTH)) begin
                                // full: drop
                            end else if (fill_reg == '0) begin
                                wr_en     = 1'b1;
                                wr_addr   = '0;
                                wr_data   = in_entry;
                                fill_next = CNT_W'(1);
                            end else begin
                                new_next   = in_entry;
                                idx_next   = ADDR_W'(fill_reg - CNT_W'(1));
                                state_next = ST_INSERT;
                            end
                        end
                        ACT_RELEASE: begin
                            if (rel_n != '0) begin
                                rem_next   = CNT_W'(rel_n);
                                state_next = ST_RELEASE;
                            end
                        end
                        ACT_DRAIN: begin
                            if (fill_reg != '0) begin
                                rem_next   = fill_reg;
                                state_next = ST_RELEASE;
                            end
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
                // read the top entry (or insertion start) ahead of need
                fill_dec = fill_next - CNT_W'(1);
                rd_addr  = fill_dec[ADDR_W-1:0];
            end

            ST_INSERT: begin
                // rd_data holds the entry at idx_reg
                rd_addr = idx_dec;
                wr_en   = 1'b1;
                wr_addr = idx_inc;
                if (goes_first(rd_data, new_reg)) begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_HEAD;
                    end else begin
                        idx_next = idx_dec;
                    end
                end else begin
                    wr_data    = new_reg;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = ST_IDLE;
                end
            end

            ST_INS_HEAD: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_reg;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end

            ST_RELEASE: begin
                // rd_data holds the entry at fill_reg - 1, the current best
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_entry_next = rd_data;
                    out_last_next  = (rem_reg == CNT_W'(1));
                    fill_next      = fill_reg - CNT_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
                fill_dec = fill_next - CNT_W'(1);
                rd_addr  = fill_dec[ADDR_W-1:0];
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ENTRY_W){1'b0}}, out_entry_reg.value, out_entry_reg.id};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/sprq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sprq_ram #(
    parameter int WIDTH  = 47,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
